### hdl/swtc_pkg.sv
// ----------------------------------------------------------------------------
// swtc_pkg: shared types and tables of the square wave tone channel
// Event codes, register numbers, the length and duty tables and the
// period limits used by the level gate.
// ----------------------------------------------------------------------------
package swtc_pkg;

	typedef enum logic [2:0] {
		MODE_REG_WRITE = 3'd0,
		MODE_ENABLE    = 3'd1,
		MODE_TIMER     = 3'd2,
		MODE_QUARTER   = 3'd3,
		MODE_HALF      = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		REG_CTRL      = 2'd0,
		REG_SWEEP     = 2'd1,
		REG_PERIOD_LO = 2'd2,
		REG_PERIOD_HI = 2'd3
	} reg_index_t;

	// Level is muted unless PERIOD_MUTE_LOW < period <= PERIOD_MAX
	localparam logic [15:0] PERIOD_MUTE_LOW = 16'd8;
	localparam logic [15:0] PERIOD_MAX      = 16'h07FF;
	localparam logic [3:0]  DECAY_FULL      = 4'd15;

	function automatic logic [7:0] length_lookup(input logic [4:0] idx);
		logic [7:0] len;
		case (idx)
			5'd0:  len = 8'd10;
			5'd1:  len = 8'd254;
			5'd2:  len = 8'd20;
			5'd3:  len = 8'd2;
			5'd4:  len = 8'd40;
			5'd5:  len = 8'd4;
			5'd6:  len = 8'd80;
			5'd7:  len = 8'd6;
			5'd8:  len = 8'd160;
			5'd9:  len = 8'd8;
			5'd10: len = 8'd60;
			5'd11: len = 8'd10;
			5'd12: len = 8'd14;
			5'd13: len = 8'd12;
			5'd14: len = 8'd26;
			5'd15: len = 8'd14;
			5'd16: len = 8'd12;
			5'd17: len = 8'd16;
			5'd18: len = 8'd24;
			5'd19: len = 8'd18;
			5'd20: len = 8'd48;
			5'd21: len = 8'd20;
			5'd22: len = 8'd96;
			5'd23: len = 8'd22;
			5'd24: len = 8'd192;
			5'd25: len = 8'd24;
			5'd26: len = 8'd72;
			5'd27: len = 8'd26;
			5'd28: len = 8'd16;
			5'd29: len = 8'd28;
			5'd30: len = 8'd32;
			5'd31: len = 8'd30;
			default: len = 8'd0;
		endcase
		return len;
	endfunction

	function automatic logic [7:0] duty_lookup(input logic [1:0] sel);
		logic [7:0] pat;
		case (sel)
			2'd0: pat = 8'b0100_0000;
			2'd1: pat = 8'b0110_0000;
			2'd2: pat = 8'b0111_1000;
			2'd3: pat = 8'b1001_1111;
			default: pat = 8'b0100_0000;
		endcase
		return pat;
	endfunction

endpackage

### hdl/swtc_ifs.sv
// ----------------------------------------------------------------------------
// swtc_ifs: item channels of the square wave tone channel
// Event channel (mode, register index, data byte) and sample channel
// (level, active), each a valid/ready handshake.
// ----------------------------------------------------------------------------
interface swtc_event_if;
	logic       valid;
	logic       ready;
	logic [2:0] mode;
	logic [1:0] reg_index;
	logic [7:0] data_byte;

	modport source (output valid, output mode, output reg_index, output data_byte,
		input ready);
	modport sink (input valid, input mode, input reg_index, input data_byte,
		output ready);
endinterface

interface swtc_sample_if;
	logic       valid;
	logic       ready;
	logic [3:0] level;
	logic       active;

	modport source (output valid, output level, output active, input ready);
	modport sink (input valid, input level, input active, output ready);
endinterface

### hdl/square_wave_tone_channel.sv
// ----------------------------------------------------------------------------
// square_wave_tone_channel: pulse tone generator with envelope and sweep
// Duty pattern, period timer, length counter, envelope and sweep unit,
// driven by one event item at a time; reports level and active per item.
// ----------------------------------------------------------------------------
// Every accepted event item (register write, enable write, timer tick,
// quarter-frame tick, half-frame tick or unused mode) produces exactly one
// sample item carrying the 4-bit level and the active flag as they stand
// after that event. The block takes one item per clock while the sample
// channel keeps up: an item is captured in the input register, applied to
// the channel state in a single combinational pass once the output register
// is free or being drained, and the resulting sample lands in the output
// register. The input register and the output register decouple the two
// channels: new events keep flowing while a sample waits, and only when
// both registers are full and the sample is not taken does the event
// channel stall. The single pass (one 16-bit shift, one 17-bit compare,
// one 16-bit subtract, a few counters) sets the clock limit. negate_extra
// (cfg_we/cfg_wdata) selects ones' (1) or two's (0) complement negation of
// the downward sweep step; write it only while no event is in flight.
module square_wave_tone_channel (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata,
	swtc_event_if.sink           events,
	swtc_sample_if.source        samples
);
	import swtc_pkg::*;

	// Input stage
	logic       in_valid_s1;
	logic [2:0] mode_s1;
	logic [1:0] reg_index_s1;
	logic [7:0] data_byte_s1;

	// Output stage
	logic       out_valid_q;
	logic [3:0] out_level_q;
	logic       out_active_q;

	logic negate_extra_q;

	// Channel state
	logic [1:0]  duty_select_q,     duty_select_d;
	logic        halt_or_loop_q,    halt_or_loop_d;
	logic        constant_volume_q, constant_volume_d;
	logic [3:0]  volume_q,          volume_d;
	logic        sweep_on_q,        sweep_on_d;
	logic [2:0]  sweep_period_q,    sweep_period_d;
	logic        sweep_down_q,      sweep_down_d;
	logic [2:0]  sweep_shift_q,     sweep_shift_d;
	logic [15:0] period_value_q,    period_value_d;
	logic [15:0] period_counter_q,  period_counter_d;
	logic [7:0]  duty_pattern_q,    duty_pattern_d;
	logic [7:0]  length_q,          length_d;
	logic        env_start_q,       env_start_d;
	logic [4:0]  env_divider_q,     env_divider_d;
	logic [3:0]  decay_q,           decay_d;
	logic        sweep_reload_q,    sweep_reload_d;
	logic [3:0]  sweep_divider_q,   sweep_divider_d;

	logic        advance;
	logic [15:0] sweep_change;
	logic [16:0] sweep_change_neg;
	logic [15:0] sweep_period_new;
	logic [3:0]  level_d;

	// Apply the held item when the output register is free or being drained
	assign advance      = in_valid_s1 && (!out_valid_q || samples.ready);
	assign events.ready = !in_valid_s1 || advance;

	assign samples.valid  = out_valid_q;
	assign samples.level  = out_level_q;
	assign samples.active = out_active_q;

	// Sweep target, computed from the current period
	always_comb begin
		sweep_change     = period_value_q >> sweep_shift_q;
		sweep_change_neg = {1'b0, sweep_change} + {16'd0, negate_extra_q};
		if (sweep_down_q) begin
			if (sweep_change_neg > {1'b0, period_value_q}) begin
				sweep_period_new = 16'd0;
			end else begin
				sweep_period_new = period_value_q - sweep_change_neg[15:0];
			end
		end else begin
			sweep_period_new = period_value_q + sweep_change;
		end
	end

	// Next channel state for the held item
	always_comb begin
		duty_select_d     = duty_select_q;
		halt_or_loop_d    = halt_or_loop_q;
		constant_volume_d = constant_volume_q;
		volume_d          = volume_q;
		sweep_on_d        = sweep_on_q;
		sweep_period_d    = sweep_period_q;
		sweep_down_d      = sweep_down_q;
		sweep_shift_d     = sweep_shift_q;
		period_value_d    = period_value_q;
		period_counter_d  = period_counter_q;
		duty_pattern_d    = duty_pattern_q;
		length_d          = length_q;
		env_start_d       = env_start_q;
		env_divider_d     = env_divider_q;
		decay_d           = decay_q;
		sweep_reload_d    = sweep_reload_q;
		sweep_divider_d   = sweep_divider_q;

		case (mode_s1)
			MODE_REG_WRITE: begin
				case (reg_index_s1)
					REG_CTRL: begin
						duty_select_d     = data_byte_s1[7:6];
						halt_or_loop_d    = data_byte_s1[5];
						constant_volume_d = data_byte_s1[4];
						volume_d          = data_byte_s1[3:0];
					end
					REG_SWEEP: begin
						sweep_on_d     = data_byte_s1[7];
						sweep_period_d = data_byte_s1[6:4];
						sweep_down_d   = data_byte_s1[3];
						sweep_shift_d  = data_byte_s1[2:0];
						sweep_reload_d = 1'b1;
					end
					REG_PERIOD_LO: begin
						period_value_d = {period_value_q[15:8], data_byte_s1};
					end
					REG_PERIOD_HI: begin
						// Upper bits above the 11-bit period are dropped
						period_value_d = {5'd0, data_byte_s1[2:0], period_value_q[7:0]};
						length_d       = length_lookup(data_byte_s1[7:3]);
						env_start_d    = 1'b1;
						duty_pattern_d = duty_lookup(duty_select_q);
					end
					default: begin
					end
				endcase
			end
			MODE_ENABLE: begin
				if (!data_byte_s1[0]) begin
					length_d = 8'd0;
				end
			end
			MODE_TIMER: begin
				// Freeze the timer and pattern while the length counter is empty
				if (length_q != 8'd0) begin
					if (period_counter_q != 16'd0) begin
						period_counter_d = period_counter_q - 16'd1;
					end else begin
						period_counter_d = period_value_q + 16'd1;
						duty_pattern_d   = {duty_pattern_q[6:0], duty_pattern_q[7]};
					end
				end
			end
			MODE_QUARTER: begin
				if (env_start_q) begin
					env_start_d   = 1'b0;
					decay_d       = DECAY_FULL;
					env_divider_d = {1'b0, volume_q} + 5'd1;
				end else if (env_divider_q != 5'd0) begin
					env_divider_d = env_divider_q - 5'd1;
				end else begin
					env_divider_d = {1'b0, volume_q} + 5'd1;
					if (decay_q != 4'd0) begin
						decay_d = decay_q - 4'd1;
					end else if (halt_or_loop_q) begin
						decay_d = DECAY_FULL;
					end
				end
			end
			MODE_HALF: begin
				if (length_q != 8'd0 && !halt_or_loop_q) begin
					length_d = length_q - 8'd1;
				end
				// Sweep unit only moves when enabled with a nonzero shift
				if (sweep_on_q && sweep_shift_q != 3'd0) begin
					period_value_d = sweep_period_new;
					if (sweep_divider_q == 4'd0) begin
						period_counter_d = sweep_period_new;
					end
					if (sweep_divider_q == 4'd0 || sweep_reload_q) begin
						sweep_divider_d = {1'b0, sweep_period_q} + 4'd1;
						sweep_reload_d  = 1'b0;
					end else begin
						sweep_divider_d = sweep_divider_q - 4'd1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Level after the item: gate by length, period range and pattern top bit
	always_comb begin
		level_d = 4'd0;
		if (length_d != 8'd0 && period_value_d > PERIOD_MUTE_LOW &&
				period_value_d <= PERIOD_MAX && duty_pattern_d[7]) begin
			level_d = constant_volume_d ? volume_d : decay_d;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (events.ready) begin
			in_valid_s1 <= events.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (events.ready && events.valid) begin
			mode_s1      <= events.mode;
			reg_index_s1 <= events.reg_index;
			data_byte_s1 <= events.data_byte;
		end
	end

	// Output register: hold until taken, load on advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (samples.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_level_q  <= level_d;
			out_active_q <= (length_d != 8'd0);
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			negate_extra_q <= 1'b0;
		end else if (cfg_we) begin
			negate_extra_q <= cfg_wdata;
		end
	end

	// Channel state: commit only when the item advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_select_q     <= 2'd0;
			halt_or_loop_q    <= 1'b0;
			constant_volume_q <= 1'b0;
			volume_q          <= 4'd0;
			sweep_on_q        <= 1'b0;
			sweep_period_q    <= 3'd0;
			sweep_down_q      <= 1'b0;
			sweep_shift_q     <= 3'd0;
			period_value_q    <= 16'd0;
			period_counter_q  <= 16'd0;
			duty_pattern_q    <= 8'd0;
			length_q          <= 8'd0;
			env_start_q       <= 1'b0;
			env_divider_q     <= 5'd0;
			decay_q           <= 4'd0;
			sweep_reload_q    <= 1'b0;
			sweep_divider_q   <= 4'd0;
		end else if (advance) begin
			duty_select_q     <= duty_select_d;
			halt_or_loop_q    <= halt_or_loop_d;
			constant_volume_q <= constant_volume_d;
			volume_q          <= volume_d;
			sweep_on_q        <= sweep_on_d;
			sweep_period_q    <= sweep_period_d;
			sweep_down_q      <= sweep_down_d;
			sweep_shift_q     <= sweep_shift_d;
			period_value_q    <= period_value_d;
			period_counter_q  <= period_counter_d;
			duty_pattern_q    <= duty_pattern_d;
			length_q          <= length_d;
			env_start_q       <= env_start_d;
			env_divider_q     <= env_divider_d;
			decay_q           <= decay_d;
			sweep_reload_q    <= sweep_reload_d;
			sweep_divider_q   <= sweep_divider_d;
		end
	end

	// The waiting sample always matches the committed length counter
	a_active_tracks_length: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_active_q == (length_q != 8'd0)))
		else $error("sample active flag disagrees with length counter");

	// A nonzero level needs a running length counter
	a_level_needs_active: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_level_q != 4'd0) |-> out_active_q)
		else $error("nonzero level while channel inactive");

	// Envelope divider never exceeds the largest reload value
	a_env_divider_range: assert property (@(posedge clk) disable iff (!arst_n)
		env_divider_q <= 5'd16)
		else $error("envelope divider out of range");

	// A stalled item stays in the input register
	a_hold_stalled_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid_s1 && !advance) |=> in_valid_s1)
		else $error("stalled item dropped from input register");

endmodule

### tb/sv/tb_square_wave_tone_channel.sv
// ----------------------------------------------------------------------------
// tb_square_wave_tone_channel: self-checking bench for the pulse tone channel
// Drives event items (register writes, enable writes, timer, quarter-frame
// and half-frame ticks) through the event channel under random idling and
// back-pressure. It mirrors the channel state in a cycle-free predictor and
// checks every level/active item on the sample channel in order.
// ----------------------------------------------------------------------------
module tb_square_wave_tone_channel;
	import swtc_pkg::*;

	// Length counter load values, indexed by data_byte[7:3] of a period-high write
	localparam logic [7:0] LENGTH_LUT [32] = '{
		8'd10, 8'd254, 8'd20, 8'd2, 8'd40, 8'd4, 8'd80, 8'd6,
		8'd160, 8'd8, 8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
		8'd12, 8'd16, 8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
		8'd192, 8'd24, 8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
	};
	// Duty patterns; bit 7 gates the output
	localparam logic [7:0] DUTY_LUT [4] = '{8'h40, 8'h60, 8'h78, 8'h9F};

	typedef struct packed {
		logic [3:0] level;
		logic       active;
	} level_item_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	swtc_event_if  events_ch ();
	swtc_sample_if samples_ch ();

	square_wave_tone_channel DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.events    (events_ch),
		.samples   (samples_ch)
	);

	always #4 clk = ~clk;

	// Levels predicted for accepted events, oldest first
	level_item_t expected_levels [$];
	int error_count = 0;
	int level_items_seen = 0;

	// Idle percentages of each side and the receiver hold-off counter
	int send_idle_pct = 26;
	int recv_idle_pct = 70;
	int ready_hold_cycles = 0;

	// ------------------------------------------------------------------------
	// Mirror of the channel state (everything clears on reset)
	// ------------------------------------------------------------------------
	logic        ch_neg_extra = 1'b0;
	logic [1:0]  ch_duty_sel  = '0;
	logic        ch_halt      = 1'b0;
	logic        ch_const     = 1'b0;
	logic [3:0]  ch_vol       = '0;
	logic        sw_en        = 1'b0;
	logic [2:0]  sw_per       = '0;
	logic        sw_neg       = 1'b0;
	logic [2:0]  sw_shift     = '0;
	logic        sw_reload    = 1'b0;
	logic [3:0]  sw_div       = '0;
	logic [15:0] ch_period    = '0;
	logic [15:0] ch_count     = '0;
	logic [7:0]  ch_pattern   = '0;
	logic [7:0]  ch_length    = '0;
	logic        env_start    = 1'b0;
	logic [4:0]  env_div      = '0;
	logic [3:0]  env_decay    = '0;

	function automatic logic [3:0] channel_level();
		if (ch_length == 8'd0 || ch_period <= PERIOD_MUTE_LOW || ch_period > PERIOD_MAX ||
				!ch_pattern[7])
			return 4'd0;
		return ch_const ? ch_vol : env_decay;
	endfunction

	// Advance the mirror by one event item
	function automatic void apply_event(input logic [2:0] mode, input logic [1:0] idx,
			input logic [7:0] data);
		logic [16:0] delta;
		case (mode)
			MODE_REG_WRITE: begin
				case (idx)
					REG_CTRL: begin
						ch_duty_sel = data[7:6];
						ch_halt     = data[5];
						ch_const    = data[4];
						ch_vol      = data[3:0];
					end
					REG_SWEEP: begin
						sw_en     = data[7];
						sw_per    = data[6:4];
						sw_neg    = data[3];
						sw_shift  = data[2:0];
						sw_reload = 1'b1;
					end
					REG_PERIOD_LO: ch_period[7:0] = data;
					default: begin
						ch_period  = {5'd0, data[2:0], ch_period[7:0]};
						ch_length  = LENGTH_LUT[data[7:3]];
						env_start  = 1'b1;
						ch_pattern = DUTY_LUT[ch_duty_sel];
					end
				endcase
			end
			MODE_ENABLE: begin
				if (!data[0])
					ch_length = 8'd0;
			end
			MODE_TIMER: begin
				if (ch_length != 8'd0) begin
					if (ch_count != 16'd0) begin
						ch_count = ch_count - 16'd1;
					end else begin
						ch_count   = ch_period + 16'd1;
						ch_pattern = {ch_pattern[6:0], ch_pattern[7]};
					end
				end
			end
			MODE_QUARTER: begin
				if (env_start) begin
					env_start = 1'b0;
					env_decay = DECAY_FULL;
					env_div   = {1'b0, ch_vol} + 5'd1;
				end else if (env_div != 5'd0) begin
					env_div = env_div - 5'd1;
				end else begin
					env_div = {1'b0, ch_vol} + 5'd1;
					if (env_decay != 4'd0)
						env_decay = env_decay - 4'd1;
					else if (ch_halt)
						env_decay = DECAY_FULL;
				end
			end
			MODE_HALF: begin
				if (ch_length != 8'd0 && !ch_halt)
					ch_length = ch_length - 8'd1;
				if (sw_en && sw_shift != 3'd0) begin
					delta = {1'b0, ch_period} >> sw_shift;
					if (sw_neg) begin
						delta = delta + {16'd0, ch_neg_extra};
						ch_period = (delta > {1'b0, ch_period}) ? 16'd0 : ch_period - delta[15:0];
					end else begin
						ch_period = ch_period + delta[15:0];
					end
					if (sw_div == 4'd0)
						ch_count = ch_period;
					if (sw_div == 4'd0 || sw_reload) begin
						sw_div    = {1'b0, sw_per} + 4'd1;
						sw_reload = 1'b0;
					end else begin
						sw_div = sw_div - 4'd1;
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void flag_error(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("ERROR @%0t: %s", $realtime, msg);
	endfunction

	// ------------------------------------------------------------------------
	// Event sender: random gap, then hold the item until it is taken.
	// valid stays high after acceptance; callers that stop sending drop it.
	// ------------------------------------------------------------------------
	task automatic send_event(input logic [2:0] mode, input logic [1:0] idx,
			input logic [7:0] data);
		level_item_t want;
		if ($urandom_range(99) < send_idle_pct) begin
			events_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		events_ch.valid     <= 1'b1;
		events_ch.mode      <= mode;
		events_ch.reg_index <= idx;
		events_ch.data_byte <= data;
		do @(posedge clk); while (!events_ch.ready);
		apply_event(mode, idx, data);
		want.level  = channel_level();
		want.active = (ch_length != 8'd0);
		expected_levels.push_back(want);
	endtask

	// Drop valid and wait until every predicted item has come back
	task automatic wait_drained();
		events_ch.valid <= 1'b0;
		while (expected_levels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_negate_extra(input logic value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we       <= 1'b0;
		ch_neg_extra = value;
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Sample receiver: check each taken item, then pick ready for the next
	// cycle. A requested hold-off keeps ready low until its counter runs out.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && samples_ch.valid && samples_ch.ready) begin
			if (expected_levels.size() == 0) begin
				flag_error($sformatf("item %0d level=%0d active=%0b arrived with none pending",
					level_items_seen, samples_ch.level, samples_ch.active));
			end else if (expected_levels[0].level !== samples_ch.level ||
					expected_levels[0].active !== samples_ch.active) begin
				flag_error($sformatf("item %0d: expected level=%0d active=%0b, got level=%0d active=%0b",
					level_items_seen, expected_levels[0].level, expected_levels[0].active,
					samples_ch.level, samples_ch.active));
			end
			if (expected_levels.size() != 0)
				void'(expected_levels.pop_front());
			level_items_seen++;
		end
		if (ready_hold_cycles > 0) begin
			samples_ch.ready  <= 1'b0;
			ready_hold_cycles <= ready_hold_cycles - 1;
		end else begin
			samples_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// ------------------------------------------------------------------------
	// Random item mix: mostly ticks over notes set up by full register
	// sequences, with stray writes, enable writes and unused modes as noise.
	// Tick items carry random index/data bits that the channel must ignore.
	// ------------------------------------------------------------------------
	task automatic send_random_event();
		int         roll;
		logic [7:0] data;
		logic [1:0] idx;
		roll = $urandom_range(99);
		data = 8'($urandom_range(255));
		idx  = 2'($urandom_range(3));
		if (roll < 8) begin
			send_event(MODE_REG_WRITE, REG_CTRL, data);
			send_event(MODE_REG_WRITE, REG_SWEEP, 8'($urandom_range(255)));
			send_event(MODE_REG_WRITE, REG_PERIOD_LO, 8'($urandom_range(255)));
			send_event(MODE_REG_WRITE, REG_PERIOD_HI, 8'($urandom_range(255)));
		end else if (roll < 14) begin
			send_event(MODE_REG_WRITE, idx, data);
		end else if (roll < 17) begin
			// Mostly keep the channel enabled
			data[0] = ($urandom_range(99) < 70);
			send_event(MODE_ENABLE, idx, data);
		end else if (roll < 52) begin
			send_event(MODE_TIMER, idx, data);
		end else if (roll < 68) begin
			send_event(MODE_QUARTER, idx, data);
		end else if (roll < 86) begin
			send_event(MODE_HALF, idx, data);
		end else if (roll < 91) begin
			send_event(3'($urandom_range(7, int'(MODE_HALF) + 1)), idx, data);
		end else begin
			send_event(MODE_REG_WRITE, REG_PERIOD_HI, data);
		end
	endtask

	// Find the low byte and shift that push an upward sweep highest
	// without passing the top of the 16-bit period
	function automatic void pick_ramp_step(input logic [15:0] period, output logic [7:0] lo,
			output logic [2:0] shift);
		logic [16:0] base;
		logic [16:0] cand;
		logic [16:0] best;
		best  = '0;
		lo    = period[7:0];
		shift = 3'd1;
		for (int b = 0; b < 256; b++) begin
			for (int s = 1; s < 8; s++) begin
				base = {1'b0, period[15:8], 8'(b)};
				cand = base + (base >> s);
				if (cand <= 17'h0FFFF && cand > best) begin
					best  = cand;
					lo    = 8'(b);
					shift = 3'(s);
				end
			end
		end
	endfunction

	// ------------------------------------------------------------------------
	// Directed events: field extremes, every mode, ignored events, enable
	// clear, sweep left alone when off or with zero shift, duty pattern kept
	// across a control write, downward sweep at period zero.
	// ------------------------------------------------------------------------
	task automatic test_event_basics();
		// Timer with the length counter empty: nothing moves
		send_event(MODE_TIMER, REG_PERIOD_HI, 8'hFF);
		send_event(MODE_REG_WRITE, REG_CTRL, 8'hBF);
		send_event(MODE_REG_WRITE, REG_PERIOD_LO, 8'hFF);
		send_event(MODE_REG_WRITE, REG_PERIOD_HI, 8'hF9);
		// Change duty select without a period-high write: running pattern stays
		send_event(MODE_REG_WRITE, REG_CTRL, 8'h40);
		repeat (3) send_event(MODE_TIMER, REG_CTRL, 8'h00);
		repeat (3) send_event(MODE_QUARTER, REG_CTRL, 8'h00);
		send_event(MODE_HALF, REG_CTRL, 8'h00);
		// Sweep down by the largest shift, then zero shift, then sweep off
		send_event(MODE_REG_WRITE, REG_SWEEP, 8'h8F);
		send_event(MODE_HALF, REG_CTRL, 8'h00);
		send_event(MODE_REG_WRITE, REG_SWEEP, 8'hF0);
		send_event(MODE_HALF, REG_CTRL, 8'h00);
		send_event(MODE_REG_WRITE, REG_SWEEP, 8'h07);
		send_event(MODE_HALF, REG_CTRL, 8'h00);
		send_event(MODE_ENABLE, REG_CTRL, 8'hFF);
		for (int m = int'(MODE_HALF) + 1; m < 8; m++)
			send_event(3'(m), REG_PERIOD_HI, 8'hFF);
		send_event(MODE_ENABLE, REG_PERIOD_HI, 8'hFE);
		send_event(MODE_TIMER, REG_CTRL, 8'h00);
		// Period zero, then a two's complement sweep down from it
		send_event(MODE_REG_WRITE, REG_PERIOD_HI, 8'h00);
		send_event(MODE_REG_WRITE, REG_PERIOD_LO, 8'h00);
		send_event(MODE_REG_WRITE, REG_SWEEP, 8'h8F);
		send_event(MODE_HALF, REG_CTRL, 8'h00);
	endtask

	// ------------------------------------------------------------------------
	// Period at 0xFFFF: the timer reload wraps to zero and the pattern turns
	// on every tick. Clear the timer counter with a clamped ones' complement
	// sweep, ramp the period up by upward sweeps (a sweep write before each
	// half tick keeps the divider from reloading the counter), fill the low
	// byte, tick, then sweep back down into the audible range.
	// ------------------------------------------------------------------------
	task automatic test_period_wrap();
		logic [7:0] lo;
		logic [2:0] shift;
		wait_drained();
		write_negate_extra(1'b1);
		send_event(MODE_REG_WRITE, REG_CTRL, 8'h3F);
		send_event(MODE_REG_WRITE, REG_PERIOD_HI, 8'h08);
		send_event(MODE_REG_WRITE, REG_PERIOD_LO, 8'h00);
		send_event(MODE_REG_WRITE, REG_SWEEP, 8'h89);
		// Downward sweep at period zero clamps; repeat until the counter is clear
		do send_event(MODE_HALF, REG_CTRL, 8'h00); while (ch_count != 16'd0);
		send_event(MODE_REG_WRITE, REG_PERIOD_HI, 8'h0F);
		send_event(MODE_REG_WRITE, REG_PERIOD_LO, 8'hFF);
		while (ch_period[15:8] != 8'hFF) begin
			pick_ramp_step(ch_period, lo, shift);
			if (lo != ch_period[7:0])
				send_event(MODE_REG_WRITE, REG_PERIOD_LO, lo);
			send_event(MODE_REG_WRITE, REG_SWEEP, {1'b1, 3'd0, 1'b0, shift});
			send_event(MODE_HALF, REG_CTRL, 8'h00);
		end
		send_event(MODE_REG_WRITE, REG_PERIOD_LO, 8'hFF);
		repeat (3) send_event(MODE_TIMER, REG_CTRL, 8'h00);
		while (ch_period > PERIOD_MAX) begin
			send_event(MODE_REG_WRITE, REG_SWEEP, 8'h89);
			send_event(MODE_HALF, REG_CTRL, 8'h00);
		end
		repeat (3) send_event(MODE_TIMER, REG_CTRL, 8'h00);
		send_event(MODE_QUARTER, REG_CTRL, 8'h00);
	endtask

	// ------------------------------------------------------------------------
	// Hold the receiver off while the sender keeps offering items so the
	// channel fills and stalls its input, then pause until all is drained.
	// ------------------------------------------------------------------------
	task automatic test_backpressure();
		int saved_send_pct;
		saved_send_pct = send_idle_pct;
		send_idle_pct = 0;
		ready_hold_cycles <= 64;
		repeat (12) send_random_event();
		send_idle_pct = saved_send_pct;
		wait_drained();
		repeat (8) send_random_event();
	endtask

	task automatic test_random_traffic(input logic negate, input int send_pct, input int recv_pct,
			input int count);
		wait_drained();
		write_negate_extra(negate);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (count) send_random_event();
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int guard;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = 1'b0;
		events_ch.valid     = 1'b0;
		events_ch.mode      = MODE_TIMER;
		events_ch.reg_index = REG_CTRL;
		events_ch.data_byte = 8'h00;
		samples_ch.ready    = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_event_basics();
		test_period_wrap();
		test_random_traffic(1'b0, 26, 70, 90);
		test_backpressure();
		test_random_traffic(1'b1, 70, 26, 90);
		test_random_traffic(1'b0, 0, 0, 90);

		// Drain, then allow the pipeline latency before judging
		events_ch.valid <= 1'b0;
		guard = 0;
		while (expected_levels.size() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
		if (expected_levels.size() != 0)
			flag_error($sformatf("%0d predicted items never arrived", expected_levels.size()));
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#4000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### filelist.f
hdl/swtc_pkg.sv
hdl/swtc_ifs.sv
hdl/square_wave_tone_channel.sv
tb/sv/tb_square_wave_tone_channel.sv
